@@ rtl/generalized_power_pair_energy_top_defines.svh @@
// Assertion macros for the pair energy kernel.
// Used by generalized_power_pair_energy_top; expects clk and rst_n in scope.
`ifndef GENERALIZED_POWER_PAIR_ENERGY_TOP_DEFINES_SVH
`define GENERALIZED_POWER_PAIR_ENERGY_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define GPE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pair energy assertion failed");

// Next-cycle implication, disabled in reset.
`define GPE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pair energy assertion failed");

`endif

@@ rtl/gpe_pkg.sv @@
// Package for the pair energy kernel: payload types, codes and constants.
// Also holds the elaboration-time root table for the exp2 unit. No dependencies.
package gpe_pkg;

  localparam int NUM_TYPES_DEF = 16;
  localparam int MAX_TERMS_DEF = 3;
  localparam int NUM_CFG_TERMS = 3;

  localparam int FRAC_BITS  = 24;
  localparam int MANT_W     = 31;
  localparam int LOG_LAT    = FRAC_BITS + 1;
  localparam int EXP_LAT    = FRAC_BITS;
  localparam int D2_W       = 48;
  localparam int SIGMA_W    = 32;
  localparam int SIGMA_FRAC = 24;
  localparam int D2_FRAC    = 32;

  localparam logic [MANT_W-1:0] MANT_ONE = MANT_W'(1) << (MANT_W - 1);

  localparam logic REQ_EVAL  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_SAT  = 2'd1;
  localparam logic [1:0] STATUS_ZERO = 2'd2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_0    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_1    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_2    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_2    = 3'd6;

  typedef struct packed {
    logic               req_type;
    logic [47:0]        dist_sq;
    logic [3:0]         type_a;
    logic [3:0]         type_b;
    logic [31:0]        sigma_value;
    logic signed [31:0] epsilon_value;
  } gpe_in_t;

  typedef struct packed {
    logic signed [63:0] energy;
    logic [1:0]         status;
  } gpe_out_t;

  // per-item flags that ride along the pipeline
  typedef struct packed {
    logic zero;
    logic ok;
    logic sig_zero;
  } gpe_flags_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bt;
    rem = v;
    res = '0;
    bt  = 64'h4000_0000_0000_0000;
    for (int s = 0; s < 32; s++) begin
      if (bt > rem) bt = bt >> 2;
    end
    for (int s = 0; s < 32; s++) begin
      if (bt != 0) begin
        if (rem >= res + bt) begin
          rem = rem - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // Q1.30 value of 2^(2^-idx), built by repeated floor square roots
  function automatic logic [31:0] exp_root(input int idx);
    logic [63:0] c;
    c = 64'h8000_0000;
    for (int j = 1; j <= FRAC_BITS; j++) begin
      if (j <= idx) c = isqrt64(c << 30);
    end
    return c[31:0];
  endfunction

endpackage

@@ rtl/gpe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; holds the packed sigma/epsilon table.
module gpe_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/gpe_delay.sv @@
// Stallable fixed-length delay line for payload that rides beside a unit.
// Standalone; no reset (payload only).
module gpe_delay #(
  parameter int WIDTH  = 8,
  parameter int STAGES = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] pipe_r [STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= din;
      for (int i = 1; i < STAGES; i++) pipe_r[i] <= pipe_r[i-1];
    end
  end

  assign dout = pipe_r[STAGES-1];

endmodule

@@ rtl/gpe_log2.sv @@
// Pipelined log2 of an unsigned integer: normalize stage, then one squaring
// step per fraction bit. Output is {top bit index, fraction}. Uses gpe_pkg.
module gpe_log2
  import gpe_pkg::*;
#(
  parameter int WIDTH = 48
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [WIDTH-1:0]                     val,
  output logic [$clog2(WIDTH)+FRAC_BITS-1:0]   log_val
);

  localparam int PW = $clog2(WIDTH);

  logic [PW-1:0]        top_idx;
  logic [WIDTH+29:0]    ext;
  logic [MANT_W-1:0]    m_r    [0:FRAC_BITS-1];
  logic [PW-1:0]        p_r    [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] frac_r [1:FRAC_BITS];

  always_comb begin
    top_idx = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (val[i]) top_idx = PW'(i);
    end
  end

  // puts the leading one at bit 30
  assign ext = {val, 30'b0} >> top_idx;

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= ext[MANT_W-1:0];
      p_r[0] <= top_idx;
    end
  end

  for (genvar i = 1; i <= FRAC_BITS; i++) begin : g_sq
    logic [61:0]          sq;
    logic                 hi;
    logic [FRAC_BITS-1:0] frac_in;

    assign sq = 62'(m_r[i-1]) * 62'(m_r[i-1]);
    assign hi = sq[61];
    if (i == 1) begin : g_first
      assign frac_in = '0;
    end else begin : g_rest
      assign frac_in = frac_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        frac_r[i] <= {frac_in[FRAC_BITS-2:0], hi};
        p_r[i]    <= p_r[i-1];
      end
    end

    if (i < FRAC_BITS) begin : g_m
      always_ff @(posedge clk) begin
        if (en) m_r[i] <= hi ? sq[61:31] : sq[60:30];
      end
    end
  end

  assign log_val = {p_r[FRAC_BITS], frac_r[FRAC_BITS]};

endmodule

@@ rtl/gpe_exp2.sv @@
// Pipelined 2^f for a 24-bit fraction: one constant multiply per bit, MSB
// first, Q1.30 mantissa. Root constants come from gpe_pkg at elaboration.
module gpe_exp2
  import gpe_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS-1:0] frac,
  output logic [MANT_W-1:0]    mant
);

  logic [MANT_W-1:0]    mant_r [1:FRAC_BITS];
  logic [FRAC_BITS-1:0] f_r    [1:FRAC_BITS-1];

  for (genvar i = 1; i <= FRAC_BITS; i++) begin : g_step
    localparam logic [31:0] ROOT = exp_root(i);
    logic [MANT_W-1:0]    m_in;
    logic [FRAC_BITS-1:0] f_in;
    logic [61:0]          prod;

    if (i == 1) begin : g_first
      assign m_in = MANT_ONE;
      assign f_in = frac;
    end else begin : g_rest
      assign m_in = mant_r[i-1];
      assign f_in = f_r[i-1];
    end

    assign prod = 62'(m_in) * 62'(ROOT[MANT_W-1:0]);

    always_ff @(posedge clk) begin
      if (en) mant_r[i] <= f_in[FRAC_BITS-i] ? prod[60:30] : m_in;
    end

    if (i < FRAC_BITS) begin : g_f
      always_ff @(posedge clk) begin
        if (en) f_r[i] <= f_in;
      end
    end
  end

  assign mant = mant_r[FRAC_BITS];

endmodule

@@ rtl/generalized_power_pair_energy_top.sv @@
// Pair energy kernel: sum of configured power terms scale*eps*(sigma/r)^alpha.
// Uses gpe_pkg, gpe_ram, gpe_delay, gpe_log2, gpe_exp2 and the defines header.
//
// Usage:
//  - in_*: valid/ready channel of request items. req_type REQ_WRITE stores
//    sigma/epsilon for (type_a, type_b) and produces no result; REQ_EVAL
//    produces exactly one out_* transfer with energy (Q32.32) and status.
//  - cfg_*: plain register write port (term count, alpha_k, scale_k); write
//    only while no evaluate is in flight.
//  - Throughput: one item per cycle unless the receiver stalls. A written
//    table entry is visible to the item accepted in the next cycle.
//  - Path from input transfer to out_valid: the 24-step squaring log2
//    pipeline and the 24-step multiply exp2 pipeline, plus one saturating
//    add stage per term.
//  - A stalled receiver freezes the whole pipeline and in_ready drops in the
//    same cycle; nothing is lost or repeated.
//  - Reset clears all valid bits and restores term_count 1, alpha_0 and
//    scale_0 1.0, the other terms 0. Table contents are undefined until written.
module generalized_power_pair_energy_top
  import gpe_pkg::*;
#(
  parameter int NUM_TYPES = NUM_TYPES_DEF,
  parameter int MAX_TERMS = MAX_TERMS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gpe_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gpe_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH  = NUM_TYPES * NUM_TYPES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LD_W   = $clog2(D2_W) + FRAC_BITS;
  localparam int LS_W   = $clog2(SIGMA_W) + FRAC_BITS;
  localparam int FL_W   = $bits(gpe_flags_t);
  localparam logic [8:0] NT9 = 9'(NUM_TYPES);
  localparam logic signed [33:0] LS_BIAS = 34'(SIGMA_FRAC * (1 << FRAC_BITS));
  localparam logic signed [33:0] LD_BIAS = 34'(D2_FRAC * (1 << FRAC_BITS));
  localparam logic [62:0] TERM_CAP = '1;
  localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};

  // ---------------- configuration ----------------
  logic [1:0]         term_count_r;
  logic signed [23:0] alpha_r [NUM_CFG_TERMS];
  logic signed [23:0] scale_r [NUM_CFG_TERMS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= 2'd1;
      alpha_r[0]   <= 24'sd65536;
      scale_r[0]   <= 24'sd65536;
      alpha_r[1]   <= '0;
      scale_r[1]   <= '0;
      alpha_r[2]   <= '0;
      scale_r[2]   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TERM_COUNT: term_count_r <= cfg_wdata[1:0];
        CFG_ALPHA_0:    alpha_r[0]   <= cfg_wdata;
        CFG_SCALE_0:    scale_r[0]   <= cfg_wdata;
        CFG_ALPHA_1:    alpha_r[1]   <= cfg_wdata;
        CFG_SCALE_1:    scale_r[1]   <= cfg_wdata;
        CFG_ALPHA_2:    alpha_r[2]   <= cfg_wdata;
        CFG_SCALE_2:    scale_r[2]   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  logic adv;
  logic in_xfer;
  logic out_vld_r;
  gpe_out_t out_data_r;

  assign adv      = !out_vld_r || out_ready;
  assign in_ready = adv;
  assign in_xfer  = in_valid && adv;

  // ---------------- table ----------------
  logic              types_ok;
  logic [16:0]       idx_full;
  logic [ADDR_W-1:0] tbl_addr;
  logic [63:0]       tbl_rdata;

  assign types_ok = (9'(in_data.type_a) < NT9) && (9'(in_data.type_b) < NT9);
  assign idx_full = 17'(in_data.type_a) * 17'(NUM_TYPES) + 17'(in_data.type_b);
  assign tbl_addr = types_ok ? idx_full[ADDR_W-1:0] : '0;

  gpe_ram #(
    .WIDTH (64),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_tbl (
    .clk  (clk),
    .we   (in_xfer && in_data.req_type == REQ_WRITE && types_ok),
    .waddr(tbl_addr),
    .wdata({in_data.sigma_value, in_data.epsilon_value}),
    .re   (adv),
    .raddr(tbl_addr),
    .rdata(tbl_rdata)
  );

  // ---------------- stage A: table data, products scale*eps ----------------
  logic              a_vld_r;
  logic [D2_W-1:0]   a_d2_r;
  logic              a_zero_r;
  logic              a_ok_r;
  logic [31:0]       sigma_a;
  logic signed [31:0] eps_a;
  gpe_flags_t        flags_a;

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (adv) a_vld_r <= in_xfer && in_data.req_type == REQ_EVAL;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_d2_r   <= in_data.dist_sq;
      a_zero_r <= in_data.dist_sq == '0;
      a_ok_r   <= types_ok;
    end
  end

  assign sigma_a = tbl_rdata[63:32];
  assign eps_a   = $signed(tbl_rdata[31:0]);
  assign flags_a = '{zero: a_zero_r, ok: a_ok_r, sig_zero: sigma_a == '0};

  // ---------------- log2 units ----------------
  logic [LD_W-1:0]       ld;
  logic [LS_W-1:0]       ls;
  logic [LOG_LAT-1:0]    vlog_r;
  gpe_flags_t            flags_l;

  gpe_log2 #(.WIDTH(D2_W)) u_log_d (.clk(clk), .en(adv), .val(a_d2_r), .log_val(ld));
  gpe_log2 #(.WIDTH(SIGMA_W)) u_log_s (.clk(clk), .en(adv), .val(sigma_a), .log_val(ls));

  gpe_delay #(.WIDTH(FL_W), .STAGES(LOG_LAT)) u_dly_fl_l (
    .clk(clk), .en(adv), .din(flags_a), .dout(flags_l)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) vlog_r <= '0;
    else if (adv) vlog_r <= {vlog_r[LOG_LAT-2:0], a_vld_r};
  end

  // ---------------- stage C: log2 x ; stage D: alpha * log2 x ----------------
  logic signed [33:0] lx_w;
  logic               c_vld_r;
  logic signed [31:0] c_lx_r;
  gpe_flags_t         c_flags_r;
  logic               d_vld_r;
  gpe_flags_t         d_flags_r;
  logic [EXP_LAT-1:0] vexp_r;
  logic [FL_W-1:0]    flags_e;

  assign lx_w = (($signed(34'(ls)) - LS_BIAS) <<< 1) - ($signed(34'(ld)) - LD_BIAS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      vexp_r  <= '0;
    end else if (adv) begin
      c_vld_r <= vlog_r[LOG_LAT-1];
      d_vld_r <= c_vld_r;
      vexp_r  <= {vexp_r[EXP_LAT-2:0], d_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_flags_r <= flags_l;
      c_lx_r    <= flags_l.sig_zero ? 32'sd0 : lx_w[31:0];
      d_flags_r <= c_flags_r;
    end
  end

  gpe_delay #(.WIDTH(FL_W), .STAGES(EXP_LAT)) u_dly_fl_e (
    .clk(clk), .en(adv), .din(d_flags_r), .dout(flags_e)
  );

  // ---------------- stages F..I ----------------
  logic       f_vld_r, g_vld_r, h_vld_r, i_vld_r;
  gpe_flags_t f_flags_r, g_flags_r, h_flags_r, i_flags_r;
  logic [MAX_TERMS-1:0] h_sat;
  logic [MAX_TERMS-1:0] h_sat_r;
  logic                 i_sat_r;
  logic signed [63:0]   i_term_r [MAX_TERMS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
      g_vld_r <= 1'b0;
      h_vld_r <= 1'b0;
      i_vld_r <= 1'b0;
    end else if (adv) begin
      f_vld_r <= vexp_r[EXP_LAT-1];
      g_vld_r <= f_vld_r;
      h_vld_r <= g_vld_r;
      i_vld_r <= h_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_flags_r <= gpe_flags_t'(flags_e);
      g_flags_r <= f_flags_r;
      h_flags_r <= g_flags_r;
      h_sat_r   <= h_sat;
      i_flags_r <= h_flags_r;
      i_sat_r   <= |h_sat_r;
    end
  end

  for (genvar k = 0; k < MAX_TERMS; k++) begin : g_lane
    localparam logic [1:0] LANE = 2'(k);
    logic signed [55:0] pe_l;
    logic signed [55:0] d_pe_r;
    logic signed [55:0] d_prod_r;
    logic [70:0]        side_e;
    logic signed [55:0] pe_e;
    logic signed [14:0] n_e;
    logic [MANT_W-1:0]  mant_e;
    logic [55:0]        mag;
    logic [54:0]        f_hi_r;
    logic [62:0]        f_lo_r;
    logic               f_neg_r, g_neg_r, h_neg_r;
    logic               f_magz_r, g_magz_r;
    logic signed [14:0] f_n_r, g_n_r;
    logic [57:0]        g_q_r;
    logic [15:0]        nm;
    logic [62:0]        r;
    logic [62:0]        h_r_r;

    // one stage longer than the log2 path so the product lines up with stage D
    gpe_delay #(.WIDTH(56), .STAGES(LOG_LAT + 1)) u_dly_pe (
      .clk(clk), .en(adv), .din(56'(scale_r[k]) * 56'(eps_a)), .dout(pe_l)
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        d_pe_r   <= pe_l;
        d_prod_r <= 56'(alpha_r[k]) * 56'(c_lx_r);
      end
    end

    // d_prod_r >>> 17 is y in Q.24: integer part above bit 40, fraction below
    gpe_exp2 u_exp (.clk(clk), .en(adv), .frac(d_prod_r[40:17]), .mant(mant_e));

    gpe_delay #(.WIDTH(71), .STAGES(EXP_LAT)) u_dly_side (
      .clk(clk), .en(adv), .din({d_pe_r, d_prod_r[55:41]}), .dout(side_e)
    );

    assign pe_e = $signed(side_e[70:15]);
    assign n_e  = $signed(side_e[14:0]);
    assign mag  = pe_e[55] ? 56'd0 - 56'(pe_e) : 56'(pe_e);

    always_ff @(posedge clk) begin
      if (adv) begin
        f_hi_r   <= 55'(mag[55:32]) * 55'(mant_e);
        f_lo_r   <= 63'(mag[31:0]) * 63'(mant_e);
        f_neg_r  <= pe_e[55];
        f_magz_r <= mag == '0;
        f_n_r    <= n_e;
        g_q_r    <= 58'({f_hi_r, 2'b00}) + 58'(f_lo_r[62:30]);
        g_neg_r  <= f_neg_r;
        g_magz_r <= f_magz_r;
        g_n_r    <= f_n_r;
      end
    end

    // shift by the integer exponent with saturation at 2^63-1
    assign nm = 16'd0 - 16'({g_n_r[14], g_n_r});
    always_comb begin
      r        = '0;
      h_sat[k] = 1'b0;
      if (g_q_r == '0) begin
        r = '0;
      end else if (!g_n_r[14]) begin
        if (g_n_r > 15'sd62 || 63'(g_q_r) > (TERM_CAP >> g_n_r[5:0])) begin
          r        = TERM_CAP;
          h_sat[k] = 1'b1;
        end else begin
          r = 63'(g_q_r) << g_n_r[5:0];
        end
      end else if (nm >= 16'd64) begin
        r = '0;
      end else begin
        r = 63'(g_q_r >> nm[5:0]);
      end
      // zero sigma with nonzero exponent: zero, or full scale for alpha < 0 and nonzero scale*eps
      if (g_flags_r.sig_zero && alpha_r[k] != 24'sd0) begin
        if (!alpha_r[k][23] || g_magz_r) begin
          r        = '0;
          h_sat[k] = 1'b0;
        end else begin
          r        = TERM_CAP;
          h_sat[k] = 1'b1;
        end
      end
      if (!(LANE < term_count_r)) begin
        r        = '0;
        h_sat[k] = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        h_r_r       <= r;
        h_neg_r     <= g_neg_r;
        i_term_r[k] <= h_neg_r ? $signed(64'd0 - {1'b0, h_r_r}) : $signed({1'b0, h_r_r});
      end
    end
  end

  // ---------------- saturating sum, one term per stage ----------------
  logic [MAX_TERMS-1:0] sum_vld_r;
  logic signed [63:0]   sum_acc_r  [MAX_TERMS];
  logic                 sum_sat_r  [MAX_TERMS];
  gpe_flags_t           sum_flags_r[MAX_TERMS];
  logic signed [63:0]   sum_term_r [MAX_TERMS][MAX_TERMS];

  for (genvar j = 0; j < MAX_TERMS; j++) begin : g_sum
    logic               vld_in;
    logic signed [63:0] acc_in;
    logic               sat_in;
    gpe_flags_t         flags_in;
    logic signed [63:0] term_in [MAX_TERMS];
    logic signed [64:0] s;
    logic               ovf;

    if (j == 0) begin : g_head
      assign vld_in   = i_vld_r;
      assign acc_in   = '0;
      assign sat_in   = i_sat_r;
      assign flags_in = i_flags_r;
      for (genvar k = 0; k < MAX_TERMS; k++) begin : g_t
        assign term_in[k] = i_term_r[k];
      end
    end else begin : g_next
      assign vld_in   = sum_vld_r[j-1];
      assign acc_in   = sum_acc_r[j-1];
      assign sat_in   = sum_sat_r[j-1];
      assign flags_in = sum_flags_r[j-1];
      for (genvar k = 0; k < MAX_TERMS; k++) begin : g_t
        assign term_in[k] = sum_term_r[j-1][k];
      end
    end

    assign s   = {acc_in[63], acc_in} + {term_in[j][63], term_in[j]};
    assign ovf = s[64] ^ s[63];

    always_ff @(posedge clk) begin
      if (!rst_n) sum_vld_r[j] <= 1'b0;
      else if (adv) sum_vld_r[j] <= vld_in;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sum_acc_r[j]   <= ovf ? (s[64] ? ACC_MIN : ACC_MAX) : s[63:0];
        sum_sat_r[j]   <= sat_in || ovf;
        sum_flags_r[j] <= flags_in;
        for (int k = 0; k < MAX_TERMS; k++) sum_term_r[j][k] <= term_in[k];
      end
    end
  end

  // ---------------- output register ----------------
  gpe_flags_t last_flags;
  assign last_flags = sum_flags_r[MAX_TERMS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (adv) out_vld_r <= sum_vld_r[MAX_TERMS-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (last_flags.zero) begin
        out_data_r.energy <= '0;
        out_data_r.status <= STATUS_ZERO;
      end else if (!last_flags.ok) begin
        out_data_r.energy <= '0;
        out_data_r.status <= STATUS_OK;
      end else begin
        out_data_r.energy <= sum_acc_r[MAX_TERMS-1];
        out_data_r.status <= sum_sat_r[MAX_TERMS-1] ? STATUS_SAT : STATUS_OK;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
`include "generalized_power_pair_energy_top_defines.svh"

  `GPE_ASSERT_NEXT(a_write_no_result, in_valid && in_ready && in_data.req_type == REQ_WRITE, !a_vld_r)
  `GPE_ASSERT_NEXT(a_stall_freeze, !adv, $stable(vlog_r) && $stable(vexp_r) && $stable(sum_vld_r))
  `GPE_ASSERT_NOW(a_zero_energy, out_valid && out_data.status == STATUS_ZERO, out_data.energy == 64'sd0)

endmodule
